[rtl/track_vertex_association_assert.svh]
// ----------------------------------------------------------------------------
// Track-vertex association assertion macros
// Concurrent assertion wrappers that compile to nothing under SYNTH.
// ----------------------------------------------------------------------------
`ifndef TRACK_VERTEX_ASSOCIATION_ASSERT_SVH
`define TRACK_VERTEX_ASSOCIATION_ASSERT_SVH

`ifndef SYNTH
`define TVA_ASSERT_IMP(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
`define TVA_ASSERT_NXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define TVA_ASSERT_IMP(name, clk, rst_n, pre, post, msg)
`define TVA_ASSERT_NXT(name, clk, rst_n, pre, post, msg)
`endif

`endif

[rtl/tva_pkg.sv]
// ----------------------------------------------------------------------------
// Track-vertex association package
// Sizes, codes and shared types of the association block.
// ----------------------------------------------------------------------------
package tva_pkg;

  localparam int unsigned MaxVertices = 64;
  localparam int unsigned MaxEntries  = 1024;

  localparam int unsigned VtxAw = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int unsigned VcntW = $clog2(MaxVertices + 1);
  localparam int unsigned EntAw = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned EcntW = $clog2(MaxEntries + 1);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_VERTEX = 2'd1,
    OP_ENTRY  = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    OUT_MATCH   = 2'd0,
    OUT_CLOSEST = 2'd1,
    OUT_NONE    = 2'd2,
    OUT_NEUTRAL = 2'd3
  } outcome_e;

  typedef struct packed {
    logic [7:0]  weight;
    logic [5:0]  vertex;
    logic [15:0] track;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic add_vertex;
    logic add_entry;
  } store_cmd_t;

  typedef struct packed {
    logic [VcntW-1:0] vertex_count;
    logic [EcntW-1:0] entry_count;
  } store_cnt_t;

endpackage

[rtl/tva_in_if.sv]
// ----------------------------------------------------------------------------
// Track-vertex association input channel
// Valid/ready channel carrying one command or query item.
// ----------------------------------------------------------------------------
interface tva_in_if;
  logic               valid;
  logic               ready;
  tva_pkg::op_e       op;
  logic [5:0]         vertex_index;
  logic [15:0]        track_id;
  logic [7:0]         track_weight;
  logic signed [15:0] z_position;
  logic               is_charged;

  modport source (
    output valid, op, vertex_index, track_id, track_weight, z_position, is_charged,
    input  ready
  );
  modport sink (
    input  valid, op, vertex_index, track_id, track_weight, z_position, is_charged,
    output ready
  );
endinterface

[rtl/tva_out_if.sv]
// ----------------------------------------------------------------------------
// Track-vertex association result channel
// Valid/ready channel carrying one association result.
// ----------------------------------------------------------------------------
interface tva_out_if;
  logic                valid;
  logic                ready;
  logic [5:0]          chosen_vertex;
  tva_pkg::outcome_e   outcome;
  logic                shared_track;

  modport source (
    output valid, chosen_vertex, outcome, shared_track,
    input  ready
  );
  modport sink (
    input  valid, chosen_vertex, outcome, shared_track,
    output ready
  );
endinterface

[rtl/tva_store.sv]
// ----------------------------------------------------------------------------
// Track-vertex association event store
// Vertex z and track entry memories with their fill counts.
// ----------------------------------------------------------------------------
module tva_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tva_pkg::store_cmd_t         cmd_i,
  input  logic [15:0]                 vertex_z_i,
  input  tva_pkg::entry_t             entry_i,
  input  logic [tva_pkg::VtxAw-1:0]   vtx_raddr_i,
  input  logic [tva_pkg::EntAw-1:0]   ent_raddr_i,
  output logic [15:0]                 vertex_z_o,
  output tva_pkg::entry_t             entry_o,
  output tva_pkg::store_cnt_t         cnt_o
);

  logic [15:0]                 vz_mem [tva_pkg::MaxVertices];
  tva_pkg::entry_t             ent_mem [tva_pkg::MaxEntries];
  logic [tva_pkg::VcntW-1:0]   vcnt_q;
  logic [tva_pkg::EcntW-1:0]   ecnt_q;
  logic                        vtx_room;
  logic                        ent_room;

  assign vtx_room = vcnt_q < tva_pkg::VcntW'(tva_pkg::MaxVertices);
  assign ent_room = ecnt_q < tva_pkg::EcntW'(tva_pkg::MaxEntries);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q <= '0;
      ecnt_q <= '0;
    end else if (cmd_i.clear) begin
      vcnt_q <= '0;
      ecnt_q <= '0;
    end else begin
      if (cmd_i.add_vertex && vtx_room) begin
        vcnt_q <= vcnt_q + 1'b1;
      end
      if (cmd_i.add_entry && ent_room) begin
        ecnt_q <= ecnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_vertex && vtx_room) begin
      vz_mem[vcnt_q[tva_pkg::VtxAw-1:0]] <= vertex_z_i;
    end
    vertex_z_o <= vz_mem[vtx_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_entry && ent_room) begin
      ent_mem[ecnt_q[tva_pkg::EntAw-1:0]] <= entry_i;
    end
    entry_o <= ent_mem[ent_raddr_i];
  end

  assign cnt_o.vertex_count = vcnt_q;
  assign cnt_o.entry_count  = ecnt_q;

endmodule

[rtl/track_vertex_association.sv]
// ----------------------------------------------------------------------------
// Track-vertex association
// Associates a particle candidate with a vertex by track weight or by z.
// ----------------------------------------------------------------------------
// The input channel in_i takes four kinds of transfer: clear the event,
// append a vertex z, append a track entry (track, vertex, weight) and query
// a candidate. Only a query produces a transfer on out_o. Clear and append
// take effect as they are accepted. A neutral query loads its result with no
// walk. A charged query walks the entry memory at one entry per cycle, then
// the vertex memories at one vertex per cycle; one memory read per cycle on
// each walk sets this pace. The result shows on out_o in the same cycle
// that in_i is ready again; in_i is ready only while no query is in
// progress. The result register lets a query run while the previous result
// waits; a finished result holds until out_o frees.
// cfg_wdata_i enables the nearest-z fallback; write it only when idle.
// Reset empties the event, clears the fallback and drops any pending result.
// ----------------------------------------------------------------------------
`include "track_vertex_association_assert.svh"

module track_vertex_association (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  tva_in_if.sink     in_i,
  tva_out_if.source  out_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ESCAN = 2'd1;
  localparam logic [1:0] ST_VSCAN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam int unsigned VtxAw = tva_pkg::VtxAw;
  localparam int unsigned CmpW  = tva_pkg::VcntW + 6;

  logic [1:0]               state_q, state_d;
  logic                     fallback_q;
  logic                     in_acc;
  logic                     q_start;
  tva_pkg::store_cmd_t      cmd;
  tva_pkg::entry_t          ent_wr;
  tva_pkg::entry_t          ent_rd;
  logic [15:0]              vz_rd;
  tva_pkg::store_cnt_t      cnt;

  logic [15:0]              trk_q;
  logic signed [15:0]       z_q;
  logic [tva_pkg::EcntW-1:0] ecnt_q;
  logic [tva_pkg::VcntW-1:0] vcnt_q;

  logic                     e_issue, e_done, v_issue, v_done;
  logic                     s1_v_q, s1_match;
  logic                     s2_v_q;
  logic [VtxAw-1:0]         s2_vx_q;
  logic [7:0]               s2_w_q;
  logic                     fwd_v_q;
  logic [VtxAw-1:0]         fwd_vx_q;
  logic [7:0]               fwd_w_q;
  logic [7:0]               bw_old;
  logic                     bw_we;

  logic [7:0]               bw_mem [tva_pkg::MaxVertices];
  logic [7:0]               bw_rd_q;
  logic [VtxAw-1:0]         bw_raddr;
  logic [tva_pkg::MaxVertices-1:0] bw_valid_q;

  logic                     t1_v_q;
  logic [VtxAw-1:0]         t1_idx_q;
  logic [7:0]               w_eff;
  logic                     improve;
  logic signed [16:0]       dz;
  logic [16:0]              dz_abs;
  logic [15:0]              z_gap;
  logic                     closer;
  logic [7:0]               best_q;
  logic [VtxAw-1:0]         bchosen_q;
  logic                     hit_q, multi_q;
  logic                     dfound_q;
  logic [15:0]              dmin_q;
  logic [VtxAw-1:0]         zchosen_q;

  logic                     out_free;
  logic                     out_valid_q;
  logic [5:0]               res_vtx_q, res_vtx_d;
  tva_pkg::outcome_e        res_out_q, res_out_d;
  logic                     res_sh_q, res_sh_d;
  logic                     res_load;
  logic [5:0]               out_vtx_q;
  tva_pkg::outcome_e        out_out_q;
  logic                     out_sh_q;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign q_start    = in_acc && (in_i.op == tva_pkg::OP_QUERY);
  assign out_free   = !out_valid_q || out_o.ready;

  always_comb begin
    cmd = '0;
    if (in_acc) begin
      unique case (in_i.op)
        tva_pkg::OP_CLEAR:  cmd.clear      = 1'b1;
        tva_pkg::OP_VERTEX: cmd.add_vertex = 1'b1;
        tva_pkg::OP_ENTRY:  cmd.add_entry  = 1'b1;
        default:            cmd            = '0;
      endcase
    end
  end

  assign ent_wr.weight = in_i.track_weight;
  assign ent_wr.vertex = in_i.vertex_index;
  assign ent_wr.track  = in_i.track_id;

  tva_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .vertex_z_i  (in_i.z_position),
    .entry_i     (ent_wr),
    .vtx_raddr_i (vcnt_q[VtxAw-1:0]),
    .ent_raddr_i (ecnt_q[tva_pkg::EntAw-1:0]),
    .vertex_z_o  (vz_rd),
    .entry_o     (ent_rd),
    .cnt_o       (cnt)
  );

  // entry walk: read entry, read vertex weight, update with forwarding
  assign e_issue  = (state_q == ST_ESCAN) && (ecnt_q < cnt.entry_count);
  assign e_done   = (state_q == ST_ESCAN) && !e_issue && !s1_v_q && !s2_v_q;
  assign s1_match = s1_v_q && (ent_rd.track == trk_q) &&
                    (CmpW'(ent_rd.vertex) < CmpW'(cnt.vertex_count));
  assign bw_raddr = (state_q == ST_VSCAN) ? vcnt_q[VtxAw-1:0] : VtxAw'(ent_rd.vertex);
  assign bw_old   = (fwd_v_q && (fwd_vx_q == s2_vx_q)) ? fwd_w_q :
                    (bw_valid_q[s2_vx_q] ? bw_rd_q : 8'd0);
  assign bw_we    = s2_v_q && (s2_w_q > bw_old);

  // vertex walk: best weight and nearest z side by side
  assign v_issue = (state_q == ST_VSCAN) && (vcnt_q < cnt.vertex_count);
  assign v_done  = (state_q == ST_VSCAN) && !v_issue && !t1_v_q;
  assign w_eff   = bw_valid_q[t1_idx_q] ? bw_rd_q : 8'd0;
  assign improve = t1_v_q && (w_eff > best_q);
  assign dz      = 17'(signed'({z_q[15], z_q})) - 17'(signed'({vz_rd[15], vz_rd}));
  assign dz_abs  = dz[16] ? 17'(-dz) : 17'(dz);
  assign z_gap   = dz_abs[15:0];
  assign closer  = t1_v_q && (!dfound_q || (z_gap < dmin_q));

  always_comb begin
    state_d   = state_q;
    res_load  = 1'b0;
    res_vtx_d = '0;
    res_out_d = tva_pkg::OUT_NONE;
    res_sh_d  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_start) begin
          if (in_i.is_charged) begin
            state_d = ST_ESCAN;
          end else begin
            state_d   = ST_DONE;
            res_load  = 1'b1;
            res_out_d = tva_pkg::OUT_NEUTRAL;
          end
        end
      end
      ST_ESCAN: begin
        if (e_done) begin
          state_d = ST_VSCAN;
        end
      end
      ST_VSCAN: begin
        if (v_done) begin
          state_d  = ST_DONE;
          res_load = 1'b1;
          if (hit_q) begin
            res_vtx_d = 6'(bchosen_q);
            res_out_d = tva_pkg::OUT_MATCH;
            res_sh_d  = multi_q;
          end else if (fallback_q && dfound_q) begin
            res_vtx_d = 6'(zchosen_q);
            res_out_d = tva_pkg::OUT_CLOSEST;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fallback_q  <= 1'b0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      fwd_v_q     <= 1'b0;
      t1_v_q      <= 1'b0;
      bw_valid_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        fallback_q <= cfg_wdata_i;
      end
      s1_v_q  <= e_issue;
      s2_v_q  <= s1_match;
      fwd_v_q <= bw_we;
      t1_v_q  <= v_issue;
      if (q_start) begin
        bw_valid_q <= '0;
      end else if (bw_we) begin
        bw_valid_q[s2_vx_q] <= 1'b1;
      end
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (bw_we) begin
      bw_mem[s2_vx_q] <= s2_w_q;
    end
    bw_rd_q <= bw_mem[bw_raddr];
  end

  always_ff @(posedge clk_i) begin
    s2_vx_q  <= VtxAw'(ent_rd.vertex);
    s2_w_q   <= ent_rd.weight;
    fwd_vx_q <= s2_vx_q;
    fwd_w_q  <= s2_w_q;
    t1_idx_q <= vcnt_q[VtxAw-1:0];
    if (q_start) begin
      trk_q    <= in_i.track_id;
      z_q      <= in_i.z_position;
      ecnt_q   <= '0;
      best_q   <= '0;
      hit_q    <= 1'b0;
      multi_q  <= 1'b0;
      dfound_q <= 1'b0;
    end
    if (e_issue) begin
      ecnt_q <= ecnt_q + 1'b1;
    end
    if (e_done) begin
      vcnt_q <= '0;
    end else if (v_issue) begin
      vcnt_q <= vcnt_q + 1'b1;
    end
    if (improve) begin
      best_q    <= w_eff;
      bchosen_q <= t1_idx_q;
      hit_q     <= 1'b1;
      multi_q   <= multi_q | hit_q;
    end
    if (closer) begin
      dmin_q    <= z_gap;
      zchosen_q <= t1_idx_q;
      dfound_q  <= 1'b1;
    end
    if (res_load) begin
      res_vtx_q <= res_vtx_d;
      res_out_q <= res_out_d;
      res_sh_q  <= res_sh_d;
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_vtx_q <= res_vtx_q;
      out_out_q <= res_out_q;
      out_sh_q  <= res_sh_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.chosen_vertex = out_vtx_q;
  assign out_o.outcome       = out_out_q;
  assign out_o.shared_track  = out_sh_q;

  `TVA_ASSERT_IMP(a_shared_only_on_match, clk_i, rst_ni, out_o.valid && (out_o.outcome != tva_pkg::OUT_MATCH), !out_o.shared_track, "shared flag on non-match result")
  `TVA_ASSERT_IMP(a_write_only_in_walk, clk_i, rst_ni, bw_we, state_q == ST_ESCAN, "weight write outside entry walk")
  `TVA_ASSERT_IMP(a_walk_drained, clk_i, rst_ni, state_q == ST_VSCAN, !s1_v_q && !s2_v_q, "entry pipeline busy in vertex walk")
  `TVA_ASSERT_NXT(a_done_delivers, clk_i, rst_ni, (state_q == ST_DONE) && out_free, out_o.valid && (state_q == ST_IDLE), "finished result not presented")

endmodule
